>>> rtl/pvt_pkg.sv
// shared types, register indexes, mode codes and the sine table
// used by the polygon vertex transform controller and datapath
// no dependencies
package pvt_pkg;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_SHX   = 3'd1;
  localparam logic [2:0] CFG_SHY   = 3'd2;
  localparam logic [2:0] CFG_ZOOM  = 3'd3;
  localparam logic [2:0] CFG_ROT   = 3'd4;

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_ZOOM      = 2'd1;
  localparam logic [1:0] MODE_ROTATE    = 2'd2;

  // ceil(2^37 / 100), exact quotient for numerators below 2^32
  localparam logic [30:0] RECIP_100 = 31'd1374389535;
  localparam int          RECIP_SH  = 37;

  // pi in q30, truncated
  localparam longint unsigned PI_Q30 = (64'd31415926 << 30) / 64'd10000000;

  typedef struct packed {
    logic wr_en;    // store the accepted vertex
    logic first;    // first vertex of a polygon loads the box
    logic setup;    // latch midpoint and rotation factors
    logic rd_en;    // issue a store read into the pipeline
    logic rd_last;  // that read is the last vertex of the run
  } pvt_cmd_t;

  typedef struct packed {
    logic adv;      // pipeline advances this cycle
    logic busy;     // any vertex still in flight
  } pvt_stat_t;

  typedef logic [15:0] sin_tab_t [0:90];

  // unsigned long division by shift and subtract, table building only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(sin(k deg) * 32768) by a q30 taylor series, capped at 32767
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t          t;
    longint unsigned   x;
    longint unsigned   term;
    longint            sum;
    longint            r;
    int                k;
    int                n;
    for (k = 0; k <= 90; k++) begin
      x = udiv64(longint'(k) * PI_Q30, 64'd180);
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 12; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + (64'sd1 <<< 14)) >>> 15;
      if (r > 32767) r = 32767;
      t[k] = r[15:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) return 16'h7fff;
    else if (v < -26'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

endpackage

>>> rtl/pvt_ram.sv
// generic single write port ram with registered read
// no dependencies
module pvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/pvt_ctrl.sv
// controller: load, setup, emit and drain sequencing, vertex count
// depends on pvt_pkg
module pvt_ctrl import pvt_pkg::*; #(
  parameter int VERTEX_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tlast,
  output logic                          in_tready,
  input  pvt_stat_t                     stat,
  output pvt_cmd_t                      cmd,
  output logic [$clog2(VERTEX_MAX)-1:0] wr_addr,
  output logic [$clog2(VERTEX_MAX)-1:0] rd_addr
);

  localparam int AW = $clog2(VERTEX_MAX);
  localparam int CW = $clog2(VERTEX_MAX + 1);

  typedef enum logic [1:0] {S_LOAD, S_SETUP, S_EMIT, S_DRAIN} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          accept;
  logic          not_full;
  logic          at_end;

  assign in_tready = (state_r == S_LOAD);
  assign accept    = in_tvalid && in_tready;
  assign not_full  = count_r < CW'(VERTEX_MAX);
  assign wr_addr   = count_r[AW-1:0];
  assign rd_addr   = idx_r;
  assign at_end    = (idx_r == AW'(count_r - CW'(1)));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.first   = (count_r == '0);
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          cmd.wr_en = not_full;
          if (not_full) count_nxt = count_r + CW'(1);
          if (in_tlast) state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.adv) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_last = at_end;
          idx_nxt     = idx_r + AW'(1);
          if (at_end) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          count_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // a store write never goes past capacity
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> count_r < CW'(VERTEX_MAX))
    else $error("store write beyond capacity");

  // a run always holds at least one vertex when emission starts
  a_setup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |-> count_r != '0)
    else $error("emission started with empty store");

  // leaving drain clears the count for the next polygon
  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && !stat.busy) |=> (count_r == '0 && state_r == S_LOAD))
    else $error("count not cleared after drain");

endmodule

>>> rtl/pvt_dp.sv
// datapath: config registers, bounding box, vertex store and the
// transform pipeline with output register; depends on pvt_pkg, pvt_ram
module pvt_dp import pvt_pkg::*; #(
  parameter int VERTEX_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic [31:0]                   in_tdata,
  input  pvt_cmd_t                      cmd,
  input  logic [$clog2(VERTEX_MAX)-1:0] wr_addr,
  input  logic [$clog2(VERTEX_MAX)-1:0] rd_addr,
  output pvt_stat_t                     stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,
  output logic                          out_tlast
);

  logic [1:0]  mode_r;
  logic [15:0] shx_r, shy_r;
  logic [9:0]  zoom_r;
  logic [8:0]  rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TRANSLATE;
      shx_r  <= '0;
      shy_r  <= '0;
      zoom_r <= 10'd100;
      rot_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[1:0];
        CFG_SHX:  shx_r  <= cfg_data;
        CFG_SHY:  shy_r  <= cfg_data;
        CFG_ZOOM: zoom_r <= cfg_data[9:0];
        CFG_ROT:  rot_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // bounding box
  logic signed [15:0] in_x, in_y;
  logic signed [15:0] minx_r, maxx_r, miny_r, maxy_r;
  assign in_x = in_tdata[15:0];
  assign in_y = in_tdata[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minx_r <= '0;
      maxx_r <= '0;
      miny_r <= '0;
      maxy_r <= '0;
    end else if (cmd.wr_en) begin
      if (cmd.first) begin
        minx_r <= in_x;
        maxx_r <= in_x;
        miny_r <= in_y;
        maxy_r <= in_y;
      end else begin
        if (in_x < minx_r) minx_r <= in_x;
        if (in_x > maxx_r) maxx_r <= in_x;
        if (in_y < miny_r) miny_r <= in_y;
        if (in_y > maxy_r) maxy_r <= in_y;
      end
    end
  end

  // midpoint truncated toward zero, rotation factors per quadrant
  logic signed [16:0] sum_x, sum_y, c_nxt, s_nxt;
  logic signed [15:0] mid_x_r, mid_y_r;
  logic signed [16:0] c_r, s_r;
  logic [8:0]         ang;
  logic [6:0]         rem;
  logic [1:0]         quad;
  logic signed [16:0] lo, hi;

  assign sum_x = 17'(minx_r) + 17'(maxx_r);
  assign sum_y = 17'(miny_r) + 17'(maxy_r);

  always_comb begin
    ang = (rot_r >= 9'd360) ? rot_r - 9'd360 : rot_r;
    priority if (ang < 9'd90) begin
      quad = 2'd0; rem = ang[6:0];
    end else if (ang < 9'd180) begin
      quad = 2'd1; rem = 7'(ang - 9'd90);
    end else if (ang < 9'd270) begin
      quad = 2'd2; rem = 7'(ang - 9'd180);
    end else begin
      quad = 2'd3; rem = 7'(ang - 9'd270);
    end
    lo = $signed({1'b0, SIN_TAB[rem]});
    hi = $signed({1'b0, SIN_TAB[7'd90 - rem]});
    unique case (quad)
      2'd0:    begin s_nxt = lo;  c_nxt = hi;  end
      2'd1:    begin s_nxt = hi;  c_nxt = -lo; end
      2'd2:    begin s_nxt = -lo; c_nxt = -hi; end
      default: begin s_nxt = -hi; c_nxt = lo;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      mid_x_r <= 16'((sum_x + ((sum_x < 0) ? 17'sd1 : 17'sd0)) >>> 1);
      mid_y_r <= 16'((sum_y + ((sum_y < 0) ? 17'sd1 : 17'sd0)) >>> 1);
      c_r     <= c_nxt;
      s_r     <= s_nxt;
    end
  end

  // vertex store
  logic        adv;
  logic [31:0] rdata;

  pvt_ram #(.WIDTH(32), .DEPTH(VERTEX_MAX)) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (in_tdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // pipeline valids
  logic rd_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic rd_l_r, s1_l_r, s2_l_r, s3_l_r, s4_l_r;

  assign adv       = !out_v_r || out_tready;
  assign stat.adv  = adv;
  assign stat.busy = rd_v_r | s1_v_r | s2_v_r | s3_v_r | s4_v_r | out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      rd_v_r  <= cmd.rd_en;
      s1_v_r  <= rd_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // stage 1: offsets from midpoint
  logic signed [15:0] s1_vx, s1_vy, s2_vx, s2_vy, s3_vx, s3_vy, s4_vx, s4_vy;
  logic signed [17:0] s1_dx, s1_dy;
  // stage 2: products
  logic signed [28:0] s2_zx, s2_zy;
  logic signed [34:0] s2_xc, s2_ys, s2_xs, s2_yc;
  // stage 3: sums, rotate quotient, zoom magnitude
  logic signed [35:0] nzx, nzy, nrx, nry;
  logic signed [35:0] mzx, mzy;
  logic signed [35:0] qrx, qry;
  logic signed [25:0] s3_rx, s3_ry, s4_rx, s4_ry;
  logic [30:0]        s3_mx, s3_my;
  logic               s3_nx, s3_ny, s4_nx, s4_ny;
  // stage 4: reciprocal products
  logic [61:0]        s4_px, s4_py;

  always_comb begin
    nzx = 36'(mid_x_r) * 36'sd100 + 36'(s2_zx);
    nzy = 36'(mid_y_r) * 36'sd100 + 36'(s2_zy);
    nrx = (36'(mid_x_r) <<< 15) + 36'(s2_xc) - 36'(s2_ys);
    nry = (36'(mid_y_r) <<< 15) + 36'(s2_xs) + 36'(s2_yc);
    qrx = (nrx + ((nrx < 0) ? 36'sd32767 : 36'sd0)) >>> 15;
    qry = (nry + ((nry < 0) ? 36'sd32767 : 36'sd0)) >>> 15;
    mzx = (nzx < 0) ? -nzx : nzx;
    mzy = (nzy < 0) ? -nzy : nzy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_l_r <= cmd.rd_last;
      s1_l_r <= rd_l_r;
      s1_vx  <= rdata[15:0];
      s1_vy  <= rdata[31:16];
      s1_dx  <= 18'($signed(rdata[15:0])) - 18'(mid_x_r);
      s1_dy  <= 18'($signed(rdata[31:16])) - 18'(mid_y_r);

      s2_l_r <= s1_l_r;
      s2_vx  <= s1_vx;
      s2_vy  <= s1_vy;
      s2_zx  <= 29'(s1_dx * $signed({1'b0, zoom_r}));
      s2_zy  <= 29'(s1_dy * $signed({1'b0, zoom_r}));
      s2_xc  <= s1_dx * c_r;
      s2_ys  <= s1_dy * s_r;
      s2_xs  <= s1_dx * s_r;
      s2_yc  <= s1_dy * c_r;

      s3_l_r <= s2_l_r;
      s3_vx  <= s2_vx;
      s3_vy  <= s2_vy;
      s3_rx  <= qrx[25:0];
      s3_ry  <= qry[25:0];
      s3_mx  <= mzx[30:0];
      s3_my  <= mzy[30:0];
      s3_nx  <= nzx < 0;
      s3_ny  <= nzy < 0;

      s4_l_r <= s3_l_r;
      s4_vx  <= s3_vx;
      s4_vy  <= s3_vy;
      s4_rx  <= s3_rx;
      s4_ry  <= s3_ry;
      s4_nx  <= s3_nx;
      s4_ny  <= s3_ny;
      s4_px  <= s3_mx * RECIP_100;
      s4_py  <= s3_my * RECIP_100;
    end
  end

  // stage 5: zoom sign, mode select, saturation into output register
  logic [24:0]        qzx, qzy;
  logic signed [25:0] zx, zy, res_x, res_y;

  always_comb begin
    qzx = s4_px[RECIP_SH +: 25];
    qzy = s4_py[RECIP_SH +: 25];
    zx  = s4_nx ? -$signed({1'b0, qzx}) : $signed({1'b0, qzx});
    zy  = s4_ny ? -$signed({1'b0, qzy}) : $signed({1'b0, qzy});
    unique case (mode_r)
      MODE_TRANSLATE: begin
        res_x = 26'(s4_vx) + 26'($signed(shx_r));
        res_y = 26'(s4_vy) + 26'($signed(shy_r));
      end
      MODE_ZOOM: begin
        res_x = zx;
        res_y = zy;
      end
      MODE_ROTATE: begin
        res_x = s4_rx;
        res_y = s4_ry;
      end
      default: begin
        res_x = 26'(s4_vx);
        res_y = 26'(s4_vy);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && s4_v_r) begin
      out_tdata <= {sat16(res_y), sat16(res_x)};
      out_tlast <= s4_l_r;
    end
  end

  assign out_tvalid = out_v_r;

  // a new result only appears after the last stage held one
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s4_v_r))
    else $error("result without pipeline source");

  // no read is issued while the pipeline is frozen
  a_read_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> adv)
    else $error("store read during stall");

endmodule

>>> rtl/polygon_vertex_transform_core.sv
// top level of the polygon vertex transform
// depends on pvt_pkg, pvt_ctrl, pvt_dp, pvt_ram
//
// usage:
//  - in_* stream carries one vertex per transaction, x in tdata[15:0],
//    y in tdata[31:16]; in_tlast marks the final vertex of a polygon
//  - vertices are stored (up to VERTEX_MAX, extras ignored) while the
//    bounding box is tracked; in_tready stays high throughout loading
//  - after the tlast transaction the block stops accepting, latches the
//    box midpoint and rotation factors, then streams every stored vertex
//    through a six stage pipeline on out_*
//  - after setup the first result passes the store read and the stages;
//    after that one result per cycle while out_tready stays high
//  - loading and emission of a polygon do not overlap; emission length is
//    set by the single store read port and the pipeline drain
//  - out_tlast is set on the last result of the run; in_tready returns
//    once that result has been taken
//  - a low out_tready with out_tvalid high freezes the whole pipeline
//    and the output register holds its transaction; nothing is dropped
//  - cfg_* writes a register (index 0 mode, 1 shift_x, 2 shift_y,
//    3 zoom_percent, 4 rotate_degrees); cfg_ready is always high and
//    writes are meant for idle periods
//  - reset (rst_n low, synchronous) empties the store, clears the box
//    and restores register defaults; no clearing pass is needed
module polygon_vertex_transform_core import pvt_pkg::*; #(
  parameter int VERTEX_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic        in_tlast,   // last_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_x[15:0], out_y[31:16]
  output logic        out_tlast,  // out_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(VERTEX_MAX);

  pvt_cmd_t      cmd;
  pvt_stat_t     stat;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // registers are plain flops, always ready for a write
  assign cfg_ready = 1'b1;

  pvt_ctrl #(.VERTEX_MAX(VERTEX_MAX)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  pvt_dp #(.VERTEX_MAX(VERTEX_MAX)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
